// ----- rtl/core/gno_pkg.sv -----
// Shared constants, types and helper functions for the octave gradient noise block.
// Used by gno_lane, gno_sum and the top level under rtl/core; depends on nothing else.
package gno_pkg;

    localparam int OCTAVES_MAX = 8;
    localparam int ENTRIES     = 2048;
    localparam int GRAD_BITS   = 16;

    localparam int X_W     = 24;
    localparam int FRAC_W  = 16;
    localparam int OSEL_W  = 3;
    localparam int GIDX_W  = 11;
    localparam int GVAL_W  = 16;
    localparam int SCALE_W = 24;
    localparam int CNT_W   = 4;
    localparam int NOISE_W = 32;
    localparam int CFG_W   = 24;

    localparam int ADDR_W = $clog2(ENTRIES);
    localparam int LANE_W = $clog2(OCTAVES_MAX + 1);
    localparam int U_W    = X_W + LANE_W;
    localparam int I_W    = U_W - FRAC_W;

    localparam int F_W   = FRAC_W + 1;
    localparam int FM_W  = FRAC_W + 2;
    localparam int C_W   = FRAC_W + 5;
    localparam int Q_W   = FRAC_W + 6;
    localparam int AB_W  = GRAD_BITS + FRAC_W + 2;
    localparam int D_W   = AB_W + 1;
    localparam int S_W   = FRAC_W + 2;
    localparam int P_W   = S_W + D_W;
    localparam int T_W   = P_W - FRAC_W;
    localparam int MAG_W = GRAD_BITS + FRAC_W;
    localparam int RM_W  = MAG_W + 1;
    localparam int QUOT_W = MAG_W + 1;

    localparam int TREE_LVL = $clog2(OCTAVES_MAX);
    localparam int TREE_N   = 1 << TREE_LVL;
    localparam int SUM_W    = QUOT_W + TREE_LVL;

    localparam int SC_LO_W  = SCALE_W / 2;
    localparam int SC_HI_W  = SCALE_W - SC_LO_W;
    localparam int FULL_W   = SUM_W + SCALE_W + 1;
    localparam int OUT_SHIFT = 30;

    localparam int LANE_STAGES = 10;
    localparam int LATENCY     = LANE_STAGES + TREE_LVL + 3;

    localparam logic [CNT_W-1:0]   COUNT_RESET = CNT_W'(1);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    typedef enum logic
    {
        REG_OCTAVE_COUNT = 1'b0,
        REG_OUTPUT_SCALE = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic                     valid;
        logic                     err;
        logic signed [QUOT_W-1:0] quot;
    } lane_out_t;

    // Reciprocal floor(2^MAG_W / k) for the constant divide of one lane.
    function automatic logic [RM_W-1:0] recip(input logic [LANE_W-1:0] k);
        int kk;
        logic [RM_W-1:0] m;
        kk = int'(k);
        unique case (kk)
            1:  m = RM_W'((65'd1 << MAG_W) / 65'd1);
            2:  m = RM_W'((65'd1 << MAG_W) / 65'd2);
            3:  m = RM_W'((65'd1 << MAG_W) / 65'd3);
            4:  m = RM_W'((65'd1 << MAG_W) / 65'd4);
            5:  m = RM_W'((65'd1 << MAG_W) / 65'd5);
            6:  m = RM_W'((65'd1 << MAG_W) / 65'd6);
            7:  m = RM_W'((65'd1 << MAG_W) / 65'd7);
            8:  m = RM_W'((65'd1 << MAG_W) / 65'd8);
            9:  m = RM_W'((65'd1 << MAG_W) / 65'd9);
            10: m = RM_W'((65'd1 << MAG_W) / 65'd10);
            11: m = RM_W'((65'd1 << MAG_W) / 65'd11);
            12: m = RM_W'((65'd1 << MAG_W) / 65'd12);
            13: m = RM_W'((65'd1 << MAG_W) / 65'd13);
            14: m = RM_W'((65'd1 << MAG_W) / 65'd14);
            15: m = RM_W'((65'd1 << MAG_W) / 65'd15);
            16: m = RM_W'((65'd1 << MAG_W) / 65'd16);
            default: m = '0;
        endcase
        return m;
    endfunction

    // Octave count as used: zero acts as one, large values saturate.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0)
            r = CNT_W'(1);
        else if (32'(c) > 32'(OCTAVES_MAX))
            r = CNT_W'(OCTAVES_MAX);
        else
            r = c;
        return r;
    endfunction

endpackage

// ----- rtl/core/gno_ram.sv -----
// Generic simple dual-read RAM: one write port, two registered read ports.
// No dependencies.
module gno_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ----- rtl/core/gno_lane.sv -----
// One octave lane: gradient bank, smootherstep blend and divide by the octave number.
// Depends on gno_pkg and gno_ram.
module gno_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [gno_pkg::LANE_W-1:0]          lane_k,
    input  logic                                wr_en,
    input  logic [gno_pkg::ADDR_W-1:0]          wr_addr,
    input  logic [gno_pkg::GRAD_BITS-1:0]       wr_data,
    input  logic                                eval_en,
    input  logic [gno_pkg::X_W-1:0]             x,
    output gno_pkg::lane_out_t                  result
);
    import gno_pkg::*;

    localparam int ONE = 1 << FRAC_W;

    // Stage 0: position in this octave and bank addresses.
    logic [U_W-1:0]    u;
    logic [I_W-1:0]    idx;
    logic [I_W:0]      idx_p1;
    logic              oob0_next;
    logic              oob1_next;
    logic [GRAD_BITS-1:0] rd0;
    logic [GRAD_BITS-1:0] rd1;

    assign u         = U_W'(x) * U_W'(lane_k);
    assign idx       = u[U_W-1:FRAC_W];
    assign idx_p1    = {1'b0, idx} + (I_W+1)'(1);
    assign oob0_next = 32'(idx) >= 32'(ENTRIES);
    assign oob1_next = 32'(idx_p1) >= 32'(ENTRIES);

    gno_ram #(
        .WIDTH (GRAD_BITS),
        .DEPTH (ENTRIES)
    ) u_bank (
        .clk    (clk),
        .we     (wr_en),
        .waddr  (wr_addr),
        .wdata  (wr_data),
        .raddr0 (ADDR_W'(idx)),
        .raddr1 (ADDR_W'(idx_p1)),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    logic [LANE_STAGES-1:0] vld_reg;
    logic [LANE_STAGES-1:0] err_reg;

    logic [FRAC_W-1:0] f1_reg;
    logic              oob0_reg;
    logic              oob1_reg;

    // Stage 1 to 2: gradients, blend weights and endpoint products.
    logic signed [GRAD_BITS-1:0] g0;
    logic signed [GRAD_BITS-1:0] g1;
    logic signed [F_W-1:0]       fs;
    logic signed [FM_W-1:0]      fm;
    logic signed [C_W-1:0]       coef;
    logic signed [F_W+C_W-1:0]   qprod;
    logic [2*FRAC_W-1:0]         ff;
    logic signed [Q_W-1:0]       q_next;
    logic signed [AB_W-1:0]      a_next;
    logic signed [AB_W-1:0]      b_next;

    assign g0     = oob0_reg ? '0 : $signed(rd0);
    assign g1     = oob1_reg ? '0 : $signed(rd1);
    assign fs     = $signed({1'b0, f1_reg});
    assign fm     = FM_W'(fs) - FM_W'(ONE);
    assign coef   = C_W'(fs) * C_W'(6) - C_W'(15 * ONE);
    assign qprod  = fs * coef;
    assign q_next = Q_W'(qprod >>> FRAC_W) + Q_W'(10 * ONE);
    assign ff     = f1_reg * f1_reg;
    assign a_next = g0 * fs;
    assign b_next = g1 * fm;

    logic [FRAC_W-1:0]      f2_reg;
    logic [FRAC_W-1:0]      ff2_reg;
    logic signed [Q_W-1:0]  q2_reg;
    logic signed [AB_W-1:0] a2_reg;
    logic signed [AB_W-1:0] b2_reg;

    // Stage 3: cube of f and endpoint difference.
    logic [2*FRAC_W-1:0]    fff;
    logic signed [D_W-1:0]  d_next;

    assign fff    = ff2_reg * f2_reg;
    assign d_next = D_W'(b2_reg) - D_W'(a2_reg);

    logic [FRAC_W-1:0]      f3_reg;
    logic signed [Q_W-1:0]  q3_reg;
    logic signed [D_W-1:0]  d3_reg;
    logic signed [AB_W-1:0] a3_reg;

    // Stage 4: smootherstep weight.
    logic signed [F_W+Q_W-1:0] sprod;
    logic signed [S_W-1:0]     s_next;

    assign sprod  = $signed({1'b0, f3_reg}) * q3_reg;
    assign s_next = S_W'(sprod >>> FRAC_W);

    logic signed [S_W-1:0]  s4_reg;
    logic signed [D_W-1:0]  d4_reg;
    logic signed [AB_W-1:0] a4_reg;

    // Stage 5: weighted difference.
    logic signed [P_W-1:0] p_next;

    assign p_next = s4_reg * d4_reg;

    logic signed [P_W-1:0]  p5_reg;
    logic signed [AB_W-1:0] a5_reg;

    // Stage 6: blended term.
    logic signed [T_W-1:0] term_next;

    assign term_next = T_W'(a5_reg) + T_W'(p5_reg >>> FRAC_W);

    logic signed [T_W-1:0] term6_reg;

    // Stage 7: sign and magnitude, since the divide truncates toward zero.
    logic             neg_next;
    logic [MAG_W-1:0] mag_next;

    assign neg_next = term6_reg[T_W-1];
    assign mag_next = MAG_W'(neg_next ? -term6_reg : term6_reg);

    logic             neg7_reg;
    logic [MAG_W-1:0] mag7_reg;

    // Stage 8: reciprocal multiply, low by at most one.
    logic [MAG_W+RM_W-1:0] rprod;
    logic [MAG_W-1:0]      q0_next;

    assign rprod   = (MAG_W+RM_W)'(mag7_reg) * (MAG_W+RM_W)'(recip(lane_k));
    assign q0_next = MAG_W'(rprod >> MAG_W);

    logic             neg8_reg;
    logic [MAG_W-1:0] mag8_reg;
    logic [MAG_W-1:0] q08_reg;

    // Stage 9: one correction step on the remainder.
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] qc_next;

    assign rem     = mag8_reg - MAG_W'(q08_reg * MAG_W'(lane_k));
    assign qc_next = q08_reg + MAG_W'(rem >= MAG_W'(lane_k));

    logic             neg9_reg;
    logic [MAG_W-1:0] qc9_reg;

    // Stage 10: restore the sign.
    logic signed [QUOT_W-1:0] quot_next;

    assign quot_next = neg9_reg ? -$signed({1'b0, qc9_reg}) : $signed({1'b0, qc9_reg});

    logic signed [QUOT_W-1:0] quot10_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            err_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LANE_STAGES-2:0], eval_en};
            err_reg <= {err_reg[LANE_STAGES-2:0], oob0_next | oob1_next};
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg     <= u[FRAC_W-1:0];
        oob0_reg   <= oob0_next;
        oob1_reg   <= oob1_next;
        f2_reg     <= f1_reg;
        ff2_reg    <= ff[2*FRAC_W-1:FRAC_W];
        q2_reg     <= q_next;
        a2_reg     <= a_next;
        b2_reg     <= b_next;
        f3_reg     <= fff[2*FRAC_W-1:FRAC_W];
        q3_reg     <= q2_reg;
        d3_reg     <= d_next;
        a3_reg     <= a2_reg;
        s4_reg     <= s_next;
        d4_reg     <= d3_reg;
        a4_reg     <= a3_reg;
        p5_reg     <= p_next;
        a5_reg     <= a4_reg;
        term6_reg  <= term_next;
        neg7_reg   <= neg_next;
        mag7_reg   <= mag_next;
        neg8_reg   <= neg7_reg;
        mag8_reg   <= mag7_reg;
        q08_reg    <= q0_next;
        neg9_reg   <= neg8_reg;
        qc9_reg    <= qc_next;
        quot10_reg <= quot_next;
    end

    assign result.valid = vld_reg[LANE_STAGES-1];
    assign result.err   = err_reg[LANE_STAGES-1];
    assign result.quot  = quot10_reg;

endmodule

// ----- rtl/core/gno_sum.sv -----
// Octave sum tree, output scaling and saturation.
// Depends on gno_pkg.
module gno_sum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gno_pkg::lane_out_t                  lanes [gno_pkg::OCTAVES_MAX],
    input  logic [gno_pkg::CNT_W-1:0]           octave_count,
    input  logic [gno_pkg::SCALE_W-1:0]         output_scale,
    output logic                                done,
    output logic signed [gno_pkg::NOISE_W-1:0]  noise,
    output logic                                range_error
);
    import gno_pkg::*;

    localparam logic signed [FULL_W-1:0] SAT_HI =
        FULL_W'((65'sd1 <<< (NOISE_W-1)) - 65'sd1);
    localparam logic signed [FULL_W-1:0] SAT_LO = -SAT_HI - 1;

    logic signed [SUM_W-1:0] heap_w   [2*TREE_N];
    logic signed [SUM_W-1:0] heap_reg [TREE_N];
    logic [TREE_LVL:0]       tv;
    logic [TREE_LVL:0]       te;
    logic                    err_leaf;

    // Leaves: octaves above the configured count contribute nothing.
    always_comb
    begin
        err_leaf = 1'b0;
        for (int j = 0; j < OCTAVES_MAX; j++)
        begin
            if (32'(j) < 32'(octave_count))
            begin
                err_leaf = err_leaf | lanes[j].err;
            end
        end
    end

    assign heap_w[0] = '0;
    assign tv[0]     = lanes[0].valid;
    assign te[0]     = err_leaf;

    for (genvar j = 0; j < TREE_N; j++)
    begin : g_leaf
        if (j < OCTAVES_MAX)
        begin : g_used
            assign heap_w[TREE_N + j] = (32'(j) < 32'(octave_count)) ?
                                        SUM_W'(lanes[j].quot) : '0;
        end
        else
        begin : g_pad
            assign heap_w[TREE_N + j] = '0;
        end
    end

    for (genvar n = 1; n < TREE_N; n++)
    begin : g_node
        always_ff @(posedge clk)
        begin
            heap_reg[n] <= heap_w[2*n] + heap_w[2*n + 1];
        end
        assign heap_w[n] = heap_reg[n];
    end

    if (TREE_LVL > 0)
    begin : g_ctl
        logic [TREE_LVL-1:0] tv_reg;
        logic [TREE_LVL-1:0] te_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tv_reg <= '0;
                te_reg <= '0;
            end
            else
            begin
                tv_reg <= tv[TREE_LVL-1:0];
                te_reg <= te[TREE_LVL-1:0];
            end
        end
        assign tv[TREE_LVL:1] = tv_reg;
        assign te[TREE_LVL:1] = te_reg;
    end

    // Scale multiply split into two partial products.
    logic signed [SUM_W+SC_LO_W:0] plo_next;
    logic signed [SUM_W+SC_HI_W:0] phi_next;

    assign plo_next = heap_w[1] * $signed({1'b0, output_scale[SC_LO_W-1:0]});
    assign phi_next = heap_w[1] * $signed({1'b0, output_scale[SCALE_W-1:SC_LO_W]});

    logic signed [SUM_W+SC_LO_W:0] plo_reg;
    logic signed [SUM_W+SC_HI_W:0] phi_reg;
    logic signed [FULL_W-1:0]      full_reg;
    logic signed [FULL_W-1:0]      full_next;
    logic signed [FULL_W-1:0]      y;
    logic signed [NOISE_W-1:0]     noise_next;
    logic signed [NOISE_W-1:0]     noise_reg;
    logic [1:0]                    sv_reg;
    logic [1:0]                    se_reg;
    logic                          done_reg;
    logic                          range_error_reg;

    assign full_next = (FULL_W'(phi_reg) <<< SC_LO_W) + FULL_W'(plo_reg);
    assign y         = full_reg >>> OUT_SHIFT;

    always_comb
    begin
        if (y > SAT_HI)
            noise_next = NOISE_W'(SAT_HI);
        else if (y < SAT_LO)
            noise_next = NOISE_W'(SAT_LO);
        else
            noise_next = NOISE_W'(y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg          <= '0;
            se_reg          <= '0;
            done_reg        <= 1'b0;
            range_error_reg <= 1'b0;
        end
        else
        begin
            sv_reg          <= {sv_reg[0], tv[TREE_LVL]};
            se_reg          <= {se_reg[0], te[TREE_LVL]};
            done_reg        <= sv_reg[1];
            range_error_reg <= se_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        full_reg  <= full_next;
        noise_reg <= noise_next;
    end

    assign done        = done_reg;
    assign noise       = noise_reg;
    assign range_error = range_error_reg;

endmodule

// ----- rtl/core/gradient_noise_1d_octaves.sv -----
// Top level of the octave gradient noise block: command port, configuration registers.
// Depends on gno_pkg, gno_lane and gno_sum.
//
// This block evaluates one-dimensional gradient noise summed over up to eight octaves.
// Software first loads the gradient tables with write items (op = write), one signed
// gradient per item for a chosen octave and index; an entry must be written before any
// evaluation reads it. An evaluate item carries a point x in unsigned Q8.16; when it has
// passed the lane pipeline, the adder tree and the output scaling, the block pulses done
// for one cycle with the noise value in signed Q16.16, saturated, and range_error set
// when some octave needed a gradient past the end of its table (that gradient then counts
// as zero). Write items give no result. Each octave owns a private gradient bank with two
// read ports and its own arithmetic lane, and the lanes feed a registered adder tree, so
// busy never rises and one item, write or evaluate, is taken every cycle. The receiver
// cannot stall: done is a strobe and the result must be captured in that cycle. Items are
// taken in order and results come back in the same order. The octave count (register 0)
// and the output scale (register 1) are written over the configuration channel, which is
// always ready; change them only while no evaluation is in flight.
module gradient_noise_1d_octaves (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               op,
    input  logic [gno_pkg::OSEL_W-1:0]         octave_sel,
    input  logic [gno_pkg::GIDX_W-1:0]         grad_index,
    input  logic signed [gno_pkg::GVAL_W-1:0]  grad_value,
    input  logic [gno_pkg::X_W-1:0]            x,
    output logic                               done,
    output logic signed [gno_pkg::NOISE_W-1:0] noise,
    output logic                               range_error,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [gno_pkg::CFG_W-1:0]          cfg_data
);
    import gno_pkg::*;

    logic                 accept;
    logic                 eval_acc;
    logic                 write_acc;
    logic [CNT_W-1:0]     count_reg;
    logic [SCALE_W-1:0]   scale_reg;
    lane_out_t            lanes [OCTAVES_MAX];

    // The pipeline always advances, so an item is taken whenever start is high.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign eval_acc  = accept && (op == OP_EVAL);
    assign write_acc = accept && (op == OP_WRITE);

    // Configuration registers. The octave count is stored already clamped so the
    // lanes and the sum tree see only legal values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OCTAVE_COUNT: count_reg <= clamp_count(cfg_data[CNT_W-1:0]);
                REG_OUTPUT_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    // One lane per octave. A write lands in the bank of the selected octave; writes
    // past the end of the table are dropped. Lane j works on octave j+1.
    for (genvar j = 0; j < OCTAVES_MAX; j++)
    begin : g_lane
        logic wr_hit;
        assign wr_hit = write_acc && (32'(octave_sel) == j) &&
                        (32'(grad_index) < 32'(ENTRIES));

        gno_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .lane_k  (LANE_W'(j + 1)),
            .wr_en   (wr_hit),
            .wr_addr (ADDR_W'(grad_index)),
            .wr_data (GRAD_BITS'(grad_value)),
            .eval_en (eval_acc),
            .x       (x),
            .result  (lanes[j])
        );
    end

    // Masking of unused octaves, the adder tree and the final scaling.
    gno_sum u_sum (
        .clk          (clk),
        .rst_n        (rst_n),
        .lanes        (lanes),
        .octave_count (count_reg),
        .output_scale (scale_reg),
        .done         (done),
        .noise        (noise),
        .range_error  (range_error)
    );

    // Every evaluation produces its result.
    a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        eval_acc |-> ##LATENCY done)
        else $error("evaluation did not produce a result on time");

    // No result appears without a matching evaluation.
    a_result_has_eval: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(eval_acc, LATENCY))
        else $error("result without a matching evaluation");

    // A write item never leads to a result.
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (write_acc && !eval_acc) |-> ##LATENCY (!done || $past(eval_acc, LATENCY)))
        else $error("write item produced a result");

    // The stored octave count stays inside the legal range.
    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (32'(count_reg) <= 32'(OCTAVES_MAX)))
        else $error("octave count out of range");

endmodule
